// ===== hdl/vts_pkg.sv =====
// Package for the VLAN tag swap stream block.
// Holds header constants and the per-request expansion type; no dependencies.
package vts_pkg;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;
  localparam logic [11:0] VID_MASK  = 12'hFFF;
  localparam logic [11:0] VID_RESET = 12'd1;

  localparam int unsigned MAX_RES  = 6;
  localparam int unsigned HELD_LEN = 5;

  localparam logic [4:0] POS_TYPE_HI = 5'd12;
  localparam logic [4:0] POS_TYPE_LO = 5'd13;
  localparam logic [4:0] POS_TAG_END = 5'd17;
  localparam logic [4:0] POS_SAT     = 5'd18;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [2:0]              cnt;
    logic                    last;
  } vts_res_t;

endpackage

// ===== hdl/vts_hdr_proc.sv =====
// Header tracker and rewrite logic: expands one input request into 0..6 bytes.
// Depends on vts_pkg.
module vts_hdr_proc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [11:0]       vid_i,
  output vts_pkg::vts_res_t res_o
);

  logic [4:0] pos_q, pos_d;
  logic       strip_q, strip_d;
  logic [7:0] held_q [vts_pkg::HELD_LEN];
  logic [4:0] rel;
  logic [2:0] k;
  logic       held_we;
  logic       is_vlan;
  logic [11:0] tci;

  assign rel     = pos_q - vts_pkg::POS_TYPE_HI;
  assign k       = rel[2:0];
  assign held_we = (pos_q >= vts_pkg::POS_TYPE_HI) && (pos_q < vts_pkg::POS_TAG_END);
  assign is_vlan = ({held_q[0], byte_i} == vts_pkg::TPID_CTAG) ||
                   ({held_q[0], byte_i} == vts_pkg::TPID_STAG);
  assign tci     = vid_i & vts_pkg::VID_MASK;

  always_comb begin
    res_o      = '0;
    res_o.last = last_i;
    if (pos_q < vts_pkg::POS_TYPE_HI || pos_q >= vts_pkg::POS_SAT) begin
      res_o.data[0] = byte_i;
      res_o.cnt     = 3'd1;
    end else if (pos_q == vts_pkg::POS_TYPE_HI) begin
      if (last_i) begin
        res_o.data[0] = byte_i;
        res_o.cnt     = 3'd1;
      end
    end else if (pos_q == vts_pkg::POS_TYPE_LO) begin
      if (is_vlan) begin
        if (last_i) begin
          res_o.data[0] = held_q[0];
          res_o.data[1] = byte_i;
          res_o.cnt     = 3'd2;
        end
      end else begin
        res_o.data[0] = vts_pkg::TPID_CTAG[15:8];
        res_o.data[1] = vts_pkg::TPID_CTAG[7:0];
        res_o.data[2] = {4'd0, tci[11:8]};
        res_o.data[3] = tci[7:0];
        res_o.data[4] = held_q[0];
        res_o.data[5] = byte_i;
        res_o.cnt     = 3'd6;
      end
    end else if (!strip_q) begin
      res_o.data[0] = byte_i;
      res_o.cnt     = 3'd1;
    end else if (pos_q < vts_pkg::POS_TAG_END) begin
      if (last_i) begin
        for (int i = 0; i < vts_pkg::HELD_LEN; i++) begin
          res_o.data[i] = (3'(i) == k) ? byte_i : held_q[i];
        end
        res_o.cnt = k + 3'd1;
      end
    end else begin
      res_o.data[0] = held_q[4];
      res_o.data[1] = byte_i;
      res_o.cnt     = 3'd2;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    strip_d = strip_q;
    if (last_i) begin
      pos_d   = '0;
      strip_d = 1'b0;
    end else begin
      if (pos_q < vts_pkg::POS_SAT) begin
        pos_d = pos_q + 5'd1;
      end
      if (pos_q == vts_pkg::POS_TYPE_LO && is_vlan) begin
        strip_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      strip_q <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      strip_q <= strip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && held_we) begin
      held_q[k] <= byte_i;
    end
  end

endmodule

// ===== hdl/vlan_tag_swap_stream_top.sv =====
// Top level of the VLAN tag swap stream block.
// Depends on vts_pkg and vts_hdr_proc.
//
// Usage:
//   Frames enter one byte per request on the s_axis channel, tlast on the
//   final byte, and leave rewritten on the m_axis channel. Untagged frames
//   get an 802.1Q tag (TPID 0x8100, VID from cfg_wdata_i) after the MAC
//   addresses; frames with TPID 0x8100 or 0x88A8 lose their outer tag.
//   Short frames pass unchanged.
//   A byte that yields output goes through the burst register, then the
//   output register, to m_axis. Throughput: one byte per cycle while
//   m_axis_tready is high; the burst register drains one byte a cycle.
//   An untagged frame's EtherType low byte expands to six bytes (input held
//   off while they drain); under tag removal the inner EtherType low byte
//   yields two and a short tagged frame flushes up to five on its last byte.
//   The burst register and the output register let one new request in
//   while a result waits on a stalled receiver; beyond that s_axis_tready
//   drops until m_axis_tready returns.
//   Reset clears the frame position and the tag state, empties both registers and
//   sets the pushed VID to 1. Write cfg_we_i only while the block is idle.
module vlan_tag_swap_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,   // push_vlan_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast
);

  logic [11:0]       vid_q;
  vts_pkg::vts_res_t res;
  logic [vts_pkg::MAX_RES-1:0][7:0] burst_q;
  logic [2:0]        cnt_q, idx_q;
  logic              blast_q;
  logic              busy, out_load, drain_done, accept;
  logic              ovalid_q;
  logic [7:0]        odata_q;
  logic              olast_q;

  assign busy          = (cnt_q != 3'd0);
  assign out_load      = busy && (!ovalid_q || m_axis_tready);
  assign drain_done    = out_load && (idx_q == cnt_q - 3'd1);
  assign s_axis_tready = !busy || drain_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_q <= vts_pkg::VID_RESET;
    end else if (cfg_we_i) begin
      vid_q <= cfg_wdata_i & vts_pkg::VID_MASK;
    end
  end

  vts_hdr_proc u_hdr_proc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .vid_i    (vid_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (accept) begin
      cnt_q <= res.cnt;
      idx_q <= '0;
    end else if (drain_done) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (out_load) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      burst_q <= res.data;
      blast_q <= res.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      odata_q <= burst_q[idx_q];
      olast_q <= blast_q && drain_done;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ===== hdl/vts_checker.sv =====
// Port-level checks for vlan_tag_swap_stream_top, attached by bind.
// Depends on the top level's port list only.
module vts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("input held off with no pending output");

  a_burst_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !s_axis_tready |=> m_axis_tvalid)
    else $error("burst did not continue after a taken byte");

endmodule

bind vlan_tag_swap_stream_top vts_checker u_vts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
